/* design/assert_macros.svh */
// Assertion helpers included by the scaler design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ZFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ZFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ZFS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* design/zfs_pkg.sv */
package zfs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PIX_W      = 32;
    localparam int BASE_W     = 20;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_START = 2'd1;
    localparam t_op OP_FETCH = 2'd2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PASS = 2'd0;
    localparam t_mode MODE_IN   = 2'd1;
    localparam t_mode MODE_OUT  = 2'd2;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_REST   = 3'd2;
    localparam t_cfg_idx CFG_BEATZ  = 3'd3;
    localparam t_cfg_idx CFG_BLEND  = 3'd4;
    localparam t_cfg_idx CFG_BEATEN = 3'd5;
    localparam t_cfg_idx CFG_SUBPIX = 3'd6;

    typedef logic [PIX_W-1:0] t_pix;

    // per-channel halving average
    function automatic t_pix avg_pix(input t_pix a, input t_pix b);
        t_pix r;
        for (int c = 0; c < 4; c++) begin
            r[c*8 +: 8] = {1'b0, a[c*8+1 +: 7]} + {1'b0, b[c*8+1 +: 7]};
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] clamp_addr(input logic [BASE_W-1:0] a,
                                                     input logic [ADDR_W-1:0] last);
        logic [ADDR_W-1:0] r;
        if (a > BASE_W'(last)) r = last;
        else r = a[ADDR_W-1:0];
        return r;
    endfunction

endpackage

/* design/zoom_feedback_frame_scaler.sv */
// Channel    | Direction | Handshake                    | Payload
// item       | in        | start / busy                 | operation col row pixel_in beat
//            |           |                              | skip_frame
// result     | out       | o_strobe, one cycle          | pixel_out zoom_value frame_mode
// config     | in        | i_cfg_valid / o_cfg_ready    | cfg_index cfg_data
//
// Load: one word per cycle, busy stays low; the store write lands in the cycle after the word is taken.
// Fetch: busy in states MUL, ADR, R0-R4, CAP, BL1 and OUT; result strobed once idle again;
//        five reads go in turn on the single store read port; no new item meanwhile.
// Start frame: result in the next cycle, busy stays low; when zooming out busy stays high
//        while the 16-step region divider runs, and the result follows its done pulse.
// Synchronous active-low reset presets control and zoom state; the store is left unwritten.
// Results cannot be stalled; o_cfg_ready is always high.
module zoom_feedback_frame_scaler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  zfs_pkg::t_op      i_operation,
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_row,
    input  logic [31:0]       i_pixel_in,
    input  logic              i_beat,
    input  logic              i_skip_frame,
    output logic              o_strobe,
    output logic [31:0]       o_pixel_out,
    output logic [8:0]        o_zoom_value,
    output zfs_pkg::t_mode    o_frame_mode,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  zfs_pkg::t_cfg_idx i_cfg_index,
    input  logic [8:0]        i_cfg_data
);
    import zfs_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_ADR  = 4'd2;
    localparam logic [3:0] ST_R0   = 4'd3;
    localparam logic [3:0] ST_R1   = 4'd4;
    localparam logic [3:0] ST_R2   = 4'd5;
    localparam logic [3:0] ST_R3   = 4'd6;
    localparam logic [3:0] ST_R4   = 4'd7;
    localparam logic [3:0] ST_CAP  = 4'd8;
    localparam logic [3:0] ST_BL1  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;
    localparam logic [3:0] ST_DIV  = 4'd11;

    // configuration
    logic [8:0] r_frame_width, r_frame_height, r_rest_zoom, r_beat_zoom;
    logic       r_blend, r_beat_en, r_subpix;
    logic [8:0] cfg_sat;

    // zoom state
    logic signed [9:0] r_pos, n_pos, pos_b, rz_s;
    logic [8:0]        r_fz, n_fz;
    t_mode             r_mode, n_mode;
    logic [8:0]        r_rw, r_rh;

    logic [3:0]  r_state;
    logic [8:0]  w_eff, h_eff;
    logic [17:0] wh;
    logic [ADDR_W-1:0] r_last;

    // load path
    logic              r_ld_we;
    logic [7:0]        r_ld_col, r_ld_row;
    t_pix              r_ld_pix;
    logic [ADDR_W-1:0] ld_addr;

    // fetch path
    logic [7:0]  r_x, r_y;
    logic        r_inframe;
    logic [15:0] r_oaddr;
    logic [13:0] r_cw, r_ch, r_px1, r_py1;
    logic [16:0] r_px2, r_py2;
    logic        r_inreg;
    logic [BASE_W-1:0] r_base;
    logic [7:0]  r_xp, r_yp;
    t_pix        r_orig, r_p0, r_p1, r_p2, r_p3;
    logic [7:0]  r_top [4];
    logic [7:0]  r_bot [4];
    logic [7:0]  n_top [4];
    logic [7:0]  n_bot [4];
    t_pix        n_pix, bil;

    logic [5:0]  c32, fp32;
    logic [8:0]  d96;
    logic [7:0]  x0, y0, dx, dy;
    logic        in_x, in_y;
    logic [24:0] sx1, sy1;
    logic [25:0] sx2, sy2;
    logic [9:0]  sxi, syi;
    logic [7:0]  xp, yp;

    logic              acc, acc_start, go_div;
    logic [ADDR_W-1:0] rd_addr;
    t_pix              rd_q;
    logic              div_w_done, div_h_done;
    logic [15:0]       q_w, q_h;

    logic       r_strobe;
    t_pix       r_pix_out;
    logic [8:0] r_zv;
    t_mode      r_fm;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;
    assign acc_start   = acc && (i_operation == OP_START);

    always_comb begin
        w_eff = r_frame_width;
        if (w_eff < 9'd4) w_eff = 9'd4;
        if (w_eff > 9'(MAX_WIDTH)) w_eff = 9'(MAX_WIDTH);
        w_eff = {w_eff[8:2], 2'b00};
        h_eff = r_frame_height;
        if (h_eff < 9'd2) h_eff = 9'd2;
        if (h_eff > 9'(MAX_HEIGHT)) h_eff = 9'(MAX_HEIGHT);
    end

    assign wh      = 18'(w_eff * h_eff);
    assign cfg_sat = (i_cfg_data > 9'd256) ? 9'd256 : i_cfg_data;

    // start-frame zoom step
    always_comb begin
        rz_s   = signed'({1'b0, r_rest_zoom});
        pos_b  = (i_beat && r_beat_en) ? signed'({1'b0, r_beat_zoom}) : r_pos;
        n_pos  = r_pos;
        n_fz   = '0;
        n_mode = MODE_PASS;
        if (!i_skip_frame) begin
            if (r_rest_zoom < r_beat_zoom) begin
                n_fz  = (pos_b > rz_s) ? pos_b[8:0] : r_rest_zoom;
                n_pos = (pos_b - 10'sd3 < -10'sd3) ? -10'sd3 : pos_b - 10'sd3;
            end else begin
                if (pos_b < rz_s) n_fz = pos_b[9] ? 9'd0 : pos_b[8:0];
                else n_fz = r_rest_zoom;
                n_pos = (pos_b + 10'sd3 > 10'sd259) ? 10'sd259 : pos_b + 10'sd3;
            end
            if (n_fz < 9'd32) n_mode = MODE_IN;
            else if (n_fz > 9'd32) n_mode = MODE_OUT;
            else n_mode = MODE_PASS;
        end
    end

    assign go_div = acc_start && (n_mode == MODE_OUT);

    zfs_div u_div_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (go_div),
        .i_dividend ({w_eff, 7'b0}),
        .i_divisor  (9'(n_fz + 9'd96)),
        .o_done     (div_w_done),
        .o_quot     (q_w)
    );

    zfs_div u_div_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (go_div),
        .i_dividend ({h_eff, 7'b0}),
        .i_divisor  (9'(n_fz + 9'd96)),
        .o_done     (div_h_done),
        .o_quot     (q_h)
    );

    // per-fetch geometry
    always_comb begin
        c32  = 6'd32 - {1'b0, r_fz[4:0]};
        fp32 = {1'b1, r_fz[4:0]};
        d96  = 9'(r_fz + 9'd96);
        x0   = (r_rw <= w_eff) ? 8'((w_eff - r_rw) >> 1) : 8'd0;
        y0   = (r_rh <= h_eff) ? 8'((h_eff - r_rh) >> 1) : 8'd0;
        dx   = r_x - x0;
        dy   = r_y - y0;
        in_x = (r_x >= x0) && ({1'b0, dx} < r_rw);
        in_y = (r_y >= y0) && ({1'b0, dy} < r_rh);
        sx1  = 25'({r_cw, 9'b0}) + 25'({r_px1, 10'b0});
        sy1  = 25'({r_ch, 9'b0}) + 25'({r_py1, 10'b0});
        sx2  = 26'd32768 + 26'({r_px2, 9'b0});
        sy2  = 26'd32768 + 26'({r_py2, 9'b0});
        if (r_mode == MODE_IN) begin
            sxi = {1'b0, sx1[24:16]};
            syi = {1'b0, sy1[24:16]};
        end else begin
            sxi = sx2[25:16];
            syi = sy2[25:16];
        end
        xp = sx1[15:8];
        yp = sy1[15:8];
    end

    always_comb begin
        unique case (r_state)
            ST_R0:   rd_addr = clamp_addr(BASE_W'(r_oaddr), r_last);
            ST_R1:   rd_addr = clamp_addr(r_base, r_last);
            ST_R2:   rd_addr = clamp_addr(r_base + BASE_W'(1), r_last);
            ST_R3:   rd_addr = clamp_addr(r_base + BASE_W'(w_eff), r_last);
            ST_R4:   rd_addr = clamp_addr(r_base + BASE_W'(w_eff) + BASE_W'(1), r_last);
            default: rd_addr = r_last;
        endcase
    end

    assign ld_addr = ADDR_W'(r_ld_row * w_eff) + ADDR_W'(r_ld_col);

    zfs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_ld_we),
        .i_waddr (ld_addr),
        .i_wdata (r_ld_pix),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    // bilinear blend and result select
    always_comb begin
        logic [15:0] st, sb, sv;
        for (int c = 0; c < 4; c++) begin
            st = 16'(r_p0[c*8 +: 8] * (8'd255 - r_xp)) + 16'(r_p1[c*8 +: 8] * r_xp);
            sb = 16'(r_p2[c*8 +: 8] * (8'd255 - r_xp)) + 16'(r_p3[c*8 +: 8] * r_xp);
            n_top[c] = st[15:8];
            n_bot[c] = sb[15:8];
            sv = 16'(r_top[c] * (8'd255 - r_yp)) + 16'(r_bot[c] * r_yp);
            bil[c*8 +: 8] = sv[15:8];
        end
        n_pix = r_orig;
        if (!r_inframe) begin
            n_pix = '0;
        end else if (r_mode == MODE_IN) begin
            n_pix = r_subpix ? bil : r_p0;
            if (r_blend) n_pix = avg_pix(n_pix, r_orig);
        end else if (r_mode == MODE_OUT && r_inreg) begin
            n_pix = r_blend ? avg_pix(r_orig, r_p0) : r_p0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
            r_rest_zoom    <= 9'd30;
            r_beat_zoom    <= 9'd30;
            r_blend        <= 1'b0;
            r_beat_en      <= 1'b0;
            r_subpix       <= 1'b1;
            r_pos          <= 10'sd30;
            r_fz           <= '0;
            r_mode         <= MODE_PASS;
            r_rw           <= '0;
            r_rh           <= '0;
            r_state        <= ST_IDLE;
            r_ld_we        <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_ld_we  <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_frame_width <= i_cfg_data;
                    CFG_HEIGHT: r_frame_height <= i_cfg_data;
                    CFG_REST: begin
                        r_rest_zoom <= cfg_sat;
                        r_pos       <= signed'({1'b0, cfg_sat});
                    end
                    CFG_BEATZ: begin
                        r_beat_zoom <= cfg_sat;
                        r_pos       <= signed'({1'b0, cfg_sat});
                    end
                    CFG_BLEND:  r_blend <= i_cfg_data[0];
                    CFG_BEATEN: r_beat_en <= i_cfg_data[0];
                    CFG_SUBPIX: r_subpix <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        priority if (i_operation == OP_LOAD) begin
                            r_ld_we <= ({1'b0, i_col} < w_eff) && ({1'b0, i_row} < h_eff);
                        end else if (i_operation == OP_START) begin
                            r_pos  <= n_pos;
                            r_fz   <= n_fz;
                            r_mode <= n_mode;
                            r_rw   <= '0;
                            r_rh   <= '0;
                            if (n_mode == MODE_OUT) begin
                                r_state <= ST_DIV;
                            end else begin
                                r_strobe <= 1'b1;
                            end
                        end else if (i_operation == OP_FETCH) begin
                            r_state <= ST_MUL;
                        end else begin
                            // unknown code: dropped, no result
                        end
                    end
                end
                ST_MUL:  r_state <= ST_ADR;
                ST_ADR:  r_state <= ST_R0;
                ST_R0:   r_state <= ST_R1;
                ST_R1:   r_state <= ST_R2;
                ST_R2:   r_state <= ST_R3;
                ST_R3:   r_state <= ST_R4;
                ST_R4:   r_state <= ST_CAP;
                ST_CAP:  r_state <= ST_BL1;
                ST_BL1:  r_state <= ST_OUT;
                ST_OUT: begin
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                ST_DIV: begin
                    if (div_w_done) begin
                        r_rw     <= {q_w[8:2], 2'b00};
                        r_rh     <= q_h[8:0];
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= ADDR_W'(wh - 18'd1);
        if (acc) begin
            r_ld_col  <= i_col;
            r_ld_row  <= i_row;
            r_ld_pix  <= i_pixel_in;
            r_x       <= i_col;
            r_y       <= i_row;
            r_inframe <= ({1'b0, i_col} < w_eff) && ({1'b0, i_row} < h_eff);
        end
        if (r_state == ST_MUL) begin
            r_oaddr <= 16'(r_y * w_eff) + 16'(r_x);
            r_cw    <= 14'(w_eff * c32);
            r_ch    <= 14'(h_eff * c32);
            r_px1   <= 14'(r_x * fp32);
            r_py1   <= 14'(r_y * fp32);
            r_px2   <= 17'(dx * d96);
            r_py2   <= 17'(dy * d96);
            r_inreg <= in_x && in_y;
        end
        if (r_state == ST_ADR) begin
            r_base <= BASE_W'(syi * w_eff) + BASE_W'(sxi);
            r_xp   <= xp;
            r_yp   <= yp;
        end
        if (r_state == ST_R1) r_orig <= rd_q;
        if (r_state == ST_R2) r_p0 <= rd_q;
        if (r_state == ST_R3) r_p1 <= rd_q;
        if (r_state == ST_R4) r_p2 <= rd_q;
        if (r_state == ST_CAP) r_p3 <= rd_q;
        if (r_state == ST_BL1) begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
        if (r_state == ST_OUT) begin
            r_pix_out <= n_pix;
            r_zv      <= '0;
            r_fm      <= MODE_PASS;
        end else begin
            r_pix_out <= '0;
            r_zv      <= r_state == ST_DIV ? r_fz : n_fz;
            r_fm      <= r_state == ST_DIV ? MODE_OUT : n_mode;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pixel_out  = r_pix_out;
    assign o_zoom_value = r_zv;
    assign o_frame_mode = r_fm;

    `ZFS_ASSERT(a_fetch_busy, i_clk, i_rst_n, (acc && i_operation == OP_FETCH) |=> busy, "fetch did not occupy the engine")
    `ZFS_ASSERT(a_load_free, i_clk, i_rst_n, (acc && i_operation == OP_LOAD) |=> !busy, "load stalled the item port")
    `ZFS_ASSERT(a_strobe_idle, i_clk, i_rst_n, o_strobe |-> !busy, "result word issued while engine busy")
    `ZFS_ASSERT(a_pos_range, i_clk, i_rst_n, (r_pos >= -10'sd3) && (r_pos <= 10'sd259), "zoom position out of range")
    `ZFS_ASSERT(a_div_sync, i_clk, i_rst_n, div_w_done == div_h_done, "region dividers out of step")
endmodule

/* design/zfs_ram.sv */
module zfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

/* design/zfs_div.sv */
module zfs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [8:0]  i_divisor,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic        r_run;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [8:0]  r_rem;
    logic [15:0] r_num;
    logic [8:0]  r_den;
    logic [9:0]  trial;
    logic        ge;

    // restoring, one quotient bit a cycle
    assign trial = {r_rem, r_num[15]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_den <= i_divisor;
        end else if (r_run) begin
            r_rem <= ge ? 9'(trial - {1'b0, r_den}) : trial[8:0];
            r_num <= {r_num[14:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

/* bench/testbench.sv */
module testbench;
    import zfs_pkg::*;

    localparam t_op OP_NONE = 2'd3;

    localparam logic [8:0] W_TAB [8] = '{0, 3, 4, 16, 13, 12, 8, 20};
    localparam logic [8:0] H_TAB [8] = '{0, 1, 2, 3, 2, 4, 5, 3};
    localparam logic [8:0] R_TAB [8] = '{0, 256, 32, 20, 511, 40, 0, 100};
    localparam logic [8:0] B_TAB [8] = '{256, 0, 32, 60, 10, 40, 255, 100};

    typedef struct {
        logic [31:0] pix;
        logic [8:0]  zv;
        t_mode       mode;
    } t_zfs_word;

    class zoom_scoreboard;
        logic [31:0] frame_mem [STORE_SIZE];
        int          zoom_pos;
        int unsigned fzoom, rgn_w, rgn_h;
        t_mode       zmode;
        int unsigned cfg_w, cfg_h, rest_z, beat_z;
        bit          blend_on, beat_on, subpix_on;
        t_zfs_word   pending_words[$];
        int          errors;

        function new();
            cfg_w = 256; cfg_h = 256; rest_z = 30; beat_z = 30;
            blend_on = 0; beat_on = 0; subpix_on = 1;
            zoom_pos = 30; fzoom = 0; zmode = MODE_PASS; rgn_w = 0; rgn_h = 0;
            errors = 0;
        endfunction

        function int unsigned eff_w();
            int unsigned w;
            w = cfg_w;
            if (w < 4) w = 4;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w & ~32'd3;
        endfunction

        function int unsigned eff_h();
            int unsigned h;
            h = cfg_h;
            if (h < 2) h = 2;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            return h;
        endfunction

        function logic [31:0] rd(longint unsigned a);
            longint unsigned last;
            last = longint'(eff_w()) * eff_h() - 1;
            if (a > last) a = last;
            return frame_mem[a];
        endfunction

        function logic [31:0] halve_mix(logic [31:0] a, logic [31:0] b);
            return ((a >> 1) & 32'h7F7F7F7F) + ((b >> 1) & 32'h7F7F7F7F);
        endfunction

        function logic [31:0] interp(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                                     logic [31:0] p3, int unsigned xp, int unsigned yp);
            logic [31:0] r;
            int unsigned top, bot, v;
            r = 0;
            for (int c = 0; c < 4; c++) begin
                top = (p0[c*8 +: 8] * (255 - xp) + p1[c*8 +: 8] * xp) >> 8;
                bot = (p2[c*8 +: 8] * (255 - xp) + p3[c*8 +: 8] * xp) >> 8;
                v = (top * (255 - yp) + bot * yp) >> 8;
                if (v > 255) v = 255;
                r[c*8 +: 8] = v[7:0];
            end
            return r;
        endfunction

        function logic [31:0] scaled_pixel(int unsigned x, int unsigned y);
            longint unsigned w, h, ds, sx, sy, base;
            int unsigned x0, y0;
            logic [31:0] orig, res;
            w = eff_w(); h = eff_h();
            orig = rd(y * w + x);
            res = orig;
            if (zmode == MODE_IN) begin
                ds = longint'(fzoom + 32) << 10;
                sx = (w * (65536 - ds)) / 2 + x * ds;
                sy = (h * (65536 - ds)) / 2 + y * ds;
                base = (sy >> 16) * w + (sx >> 16);
                if (subpix_on)
                    res = interp(rd(base), rd(base + 1), rd(base + w), rd(base + w + 1),
                                 (sx >> 8) & 8'hFF, (sy >> 8) & 8'hFF);
                else
                    res = rd(base);
                if (blend_on) res = halve_mix(res, orig);
            end else if (zmode == MODE_OUT) begin
                ds = longint'(fzoom + 96) << 9;
                x0 = (rgn_w <= w) ? (w - rgn_w) / 2 : 0;
                y0 = (rgn_h <= h) ? (h - rgn_h) / 2 : 0;
                if (x >= x0 && x - x0 < rgn_w && y >= y0 && y - y0 < rgn_h) begin
                    sx = 32768 + longint'(x - x0) * ds;
                    sy = 32768 + longint'(y - y0) * ds;
                    res = rd((sy >> 16) * w + (sx >> 16));
                    if (blend_on) res = halve_mix(orig, res);
                end
            end
            return res;
        endfunction

        function void begin_frame(bit bt, bit skp);
            int f;
            int unsigned ds;
            t_zfs_word wd;
            if (skp) begin
                zmode = MODE_PASS; fzoom = 0; rgn_w = 0; rgn_h = 0;
            end else begin
                if (bt && beat_on) zoom_pos = beat_z;
                if (rest_z < beat_z) begin
                    f = (zoom_pos > int'(rest_z)) ? zoom_pos : rest_z;
                    zoom_pos -= 3;
                    if (zoom_pos < -3) zoom_pos = -3;
                end else begin
                    f = (zoom_pos < int'(rest_z)) ? zoom_pos : rest_z;
                    zoom_pos += 3;
                    if (zoom_pos > 259) zoom_pos = 259;
                end
                if (f < 0) f = 0;
                fzoom = f;
                rgn_w = 0; rgn_h = 0;
                if (fzoom < 32) zmode = MODE_IN;
                else if (fzoom > 32) begin
                    ds = (fzoom + 96) << 9;
                    zmode = MODE_OUT;
                    rgn_w = ((eff_w() << 16) / ds) & ~32'd3;
                    rgn_h = (eff_h() << 16) / ds;
                end else zmode = MODE_PASS;
            end
            wd.pix = 0; wd.zv = fzoom[8:0]; wd.mode = zmode;
            pending_words.push_back(wd);
        endfunction

        function void note_item(t_op op, logic [7:0] c, logic [7:0] r, logic [31:0] p,
                                bit bt, bit skp);
            t_zfs_word wd;
            int unsigned w, h;
            w = eff_w(); h = eff_h();
            case (op)
                OP_LOAD: if (c < w && r < h) frame_mem[r * w + c] = p;
                OP_START: begin_frame(bt, skp);
                OP_FETCH: begin
                    wd.pix = (c < w && r < h) ? scaled_pixel(c, r) : 32'd0;
                    wd.zv = 0; wd.mode = MODE_PASS;
                    pending_words.push_back(wd);
                end
                default: ;
            endcase
        endfunction

        function void note_cfg(t_cfg_idx idx, logic [8:0] d);
            int unsigned z;
            z = (d > 256) ? 256 : d;
            case (idx)
                CFG_WIDTH:  cfg_w = d;
                CFG_HEIGHT: cfg_h = d;
                CFG_REST:   begin rest_z = z; zoom_pos = z; end
                CFG_BEATZ:  begin beat_z = z; zoom_pos = z; end
                CFG_BLEND:  blend_on = d[0];
                CFG_BEATEN: beat_on = d[0];
                CFG_SUBPIX: subpix_on = d[0];
                default: ;
            endcase
        endfunction

        function void check_word(logic [31:0] pix, logic [8:0] zv, t_mode mode);
            t_zfs_word want;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word pix=%h zoom=%0d mode=%0d", $time, pix, zv, mode);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (pix !== want.pix) begin
                $display("%0t: pixel_out expected %h actual %h", $time, want.pix, pix);
                errors++;
            end
            if (zv !== want.zv) begin
                $display("%0t: zoom_value expected %0d actual %0d", $time, want.zv, zv);
                errors++;
            end
            if (mode !== want.mode) begin
                $display("%0t: frame_mode expected %0d actual %0d", $time, want.mode, mode);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_op         i_operation = OP_LOAD;
    logic [7:0]  i_col = 0, i_row = 0;
    logic [31:0] i_pixel_in = 0;
    logic        i_beat = 0, i_skip_frame = 0;
    logic        o_strobe;
    logic [31:0] o_pixel_out;
    logic [8:0]  o_zoom_value;
    t_mode       o_frame_mode;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_WIDTH;
    logic [8:0]  i_cfg_data = 0;

    zoom_scoreboard sb = new();
    bit calm = 0;

    zoom_feedback_frame_scaler uut (.*);

    always #1 i_clk = ~i_clk;

    // outputs and inputs are stable at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_word(o_pixel_out, o_zoom_value, o_frame_mode);
            if (start && !busy)
                sb.note_item(i_operation, i_col, i_row, i_pixel_in, i_beat, i_skip_frame);
            if (i_cfg_valid && o_cfg_ready) sb.note_cfg(i_cfg_index, i_cfg_data);
        end
    end

    initial begin
        #8000000;
        $display("zoom_feedback_frame_scaler regression: fail");
        $finish;
    end

    task automatic send(t_op op, logic [7:0] c, logic [7:0] r, logic [31:0] p,
                        bit bt, bit skp);
        bit acc;
        if (!calm && $urandom_range(99) < 7) begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1; i_operation <= op; i_col <= c; i_row <= r;
        i_pixel_in <= p; i_beat <= bt; i_skip_frame <= skp;
        acc = 0;
        while (!acc) begin
            @(negedge i_clk);
            acc = start && !busy;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [8:0] d);
        bit acc;
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= d;
        acc = 0;
        while (!acc) begin
            @(negedge i_clk);
            acc = i_cfg_valid && o_cfg_ready;
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic fill_frame();
        for (int r = 0; r < sb.eff_h(); r++)
            for (int c = 0; c < sb.eff_w(); c++)
                send(OP_LOAD, 8'(c), 8'(r), $urandom, 1'b0, 1'b0);
    endtask

    task automatic pick_xy(output logic [7:0] c, output logic [7:0] r);
        if ($urandom_range(9) == 0) begin
            c = 8'($urandom_range(255)); r = 8'($urandom_range(255));
        end else begin
            c = 8'($urandom_range(sb.eff_w() - 1)); r = 8'($urandom_range(sb.eff_h() - 1));
        end
    endtask

    task automatic run_items(int n);
        logic [7:0] c, r;
        int sel;
        for (int k = 0; k < n; k++) begin
            pick_xy(c, r);
            sel = (k < 4) ? 50 : $urandom_range(99);
            if (sel < 16)
                send(OP_START, c, r, $urandom, 1'($urandom_range(1)),
                     $urandom_range(11) == 0);
            else if (sel < 78) send(OP_FETCH, c, r, $urandom, 1'($urandom_range(1)), 1'b0);
            else if (sel < 94) send(OP_LOAD, c, r, $urandom, 1'($urandom_range(1)), 1'b0);
            else send(OP_NONE, c, r, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    function automatic logic [8:0] rand_zoom();
        case ($urandom_range(5))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'h1FF;
            3: return 9'd32;
            4: return 9'($urandom_range(0, 40));
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(CFG_WIDTH, 9'd8);
        write_reg(CFG_HEIGHT, 9'd4);
        i_cfg_valid <= 0;
        @(posedge i_clk);
        fill_frame();
        send(OP_FETCH, 8'd255, 8'd255, 32'd0, 1'b0, 1'b0);
        send(OP_FETCH, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
        run_items(30);
        settle();

        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph == 4 || ph == 5);
            if (ph < 8) begin
                write_reg(CFG_WIDTH, W_TAB[ph]);
                write_reg(CFG_HEIGHT, H_TAB[ph]);
            end else if (ph % 2 == 0) begin
                write_reg(CFG_WIDTH, 9'($urandom_range(0, 12)));
                write_reg(CFG_HEIGHT, 9'($urandom_range(0, 6)));
            end
            // odd late phases keep the zoom state so fetches see the old region
            if (ph < 8 || ph % 2 == 0) begin
                write_reg(CFG_REST, ph < 8 ? R_TAB[ph] : rand_zoom());
                write_reg(CFG_BEATZ, ph < 8 ? B_TAB[ph] : rand_zoom());
            end else begin
                write_reg(CFG_WIDTH, 9'($urandom_range(0, 12)));
                write_reg(CFG_HEIGHT, 9'($urandom_range(0, 6)));
            end
            write_reg(CFG_BLEND, 9'($urandom_range(1)));
            write_reg(CFG_BEATEN, ph == 0 ? 9'd1 : 9'($urandom_range(1)));
            write_reg(CFG_SUBPIX, ph == 1 ? 9'd0 : 9'($urandom_range(1)));
            i_cfg_valid <= 0;
            @(posedge i_clk);
            fill_frame();
            run_items(28);
            settle();
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("zoom_feedback_frame_scaler regression: pass");
        else
            $display("zoom_feedback_frame_scaler regression: fail");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/zfs_pkg.sv
design/zfs_ram.sv
design/zfs_div.sv
design/zoom_feedback_frame_scaler.sv
bench/testbench.sv
